[rtl/pit_pkg.sv]
// Shared constants for the PWM interval timer: request codes, register indexes and widths.
`default_nettype none
package pit_pkg;

    localparam int unsigned NumChannelsDef = 4;
    localparam int unsigned MaxChannels    = 4;

    localparam int unsigned CountW = 16;
    localparam int unsigned ReqW   = 3;
    localparam int unsigned ChanW  = 2;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned ModeW    = 3;
    localparam int unsigned SetupW   = 3 * MaxChannels;

    // Request codes.
    localparam logic [ReqW-1:0] REQ_TICK  = 3'd0;
    localparam logic [ReqW-1:0] REQ_START = 3'd1;
    localparam logic [ReqW-1:0] REQ_STOP  = 3'd2;
    localparam logic [ReqW-1:0] REQ_WRITE = 3'd3;
    localparam logic [ReqW-1:0] REQ_CLEAR = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_PRESCALE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RELOAD   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MODE     = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SETUP    = 2'd3;

    // Bit positions in the mode register.
    localparam int unsigned MODE_DOWN   = 0;
    localparam int unsigned MODE_SINGLE = 1;
    localparam int unsigned MODE_IRQ_EN = 2;

    // Bit positions within one channel's setup field.
    localparam int unsigned CH_ENABLE   = 0;
    localparam int unsigned CH_MODE2    = 1;
    localparam int unsigned CH_ACT_LOW  = 2;

    localparam logic [CountW-1:0] ReloadReset = 16'hFFFF;

endpackage
`default_nettype wire

[rtl/pwm_interval_timer.sv]
// Four-channel interval timer with prescaler, auto-reload and PWM compare outputs.
// An accepted item first updates the timer state, then the outputs are registered from it.
// One item per cycle when not stalled; counter update and PWM compare each take one stage.
// Up to two items may be in flight, so an item is taken while a result waits to be taken.
// Reset (synchronous, active low) clears the counters, flags and compare values and
// loads the register defaults (reload value all ones, everything else zero).
`default_nettype none
module pwm_interval_timer #(
    parameter int unsigned NUM_CHANNELS = pit_pkg::NumChannelsDef
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_cfg_we,
    input  wire logic [pit_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [pit_pkg::CfgDataW-1:0]  i_cfg_data,

    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pit_pkg::ReqW-1:0]      i_req_type,
    input  wire logic [pit_pkg::ChanW-1:0]     i_channel,
    input  wire logic [pit_pkg::CountW-1:0]    i_value,

    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pit_pkg::MaxChannels-1:0]    o_pwm_out,
    output logic [pit_pkg::CountW-1:0]         o_count_value,
    output logic                               o_update_flag,
    output logic                               o_interrupt_request,
    output logic                               o_counting
);

    localparam int unsigned CW = pit_pkg::CountW;

    // Configuration registers.
    logic [CW-1:0]                   r_prescale;
    logic [CW-1:0]                   r_reload;
    logic [pit_pkg::ModeW-1:0]       r_mode;
    logic [pit_pkg::SetupW-1:0]      r_setup;

    // Timer state.
    logic [CW-1:0] r_presc_cnt, n_presc_cnt;
    logic [CW-1:0] r_count,     n_count;
    logic          r_run,       n_run;
    logic          r_wrap,      n_wrap;
    logic [CW-1:0] r_cmp_active  [NUM_CHANNELS];
    logic [CW-1:0] n_cmp_active  [NUM_CHANNELS];
    logic [CW-1:0] r_cmp_pending [NUM_CHANNELS];
    logic [CW-1:0] n_cmp_pending [NUM_CHANNELS];

    // Pipeline control.
    logic r_s1_valid;
    logic r_out_valid;
    logic in_accept;
    logic s1_move;
    logic out_take;

    logic [pit_pkg::MaxChannels-1:0] pwm_levels;
    logic down;
    logic step;
    logic wrapped;
    logic load_cmp;

    assign out_take  = r_out_valid && !i_stall;
    assign s1_move   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !s1_move;
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign down      = r_mode[pit_pkg::MODE_DOWN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_reload   <= pit_pkg::ReloadReset;
            r_mode     <= '0;
            r_setup    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pit_pkg::CFG_PRESCALE: r_prescale <= i_cfg_data;
                pit_pkg::CFG_RELOAD:   r_reload   <= i_cfg_data;
                pit_pkg::CFG_MODE:     r_mode     <= i_cfg_data[pit_pkg::ModeW-1:0];
                pit_pkg::CFG_SETUP:    r_setup    <= i_cfg_data[pit_pkg::SetupW-1:0];
                default: ;
            endcase
        end
    end

    // Next state for one accepted item.
    always_comb begin
        n_presc_cnt   = r_presc_cnt;
        n_count       = r_count;
        n_run         = r_run;
        n_wrap        = r_wrap;
        n_cmp_active  = r_cmp_active;
        n_cmp_pending = r_cmp_pending;
        step          = 1'b0;
        wrapped       = 1'b0;
        load_cmp      = 1'b0;

        case (i_req_type)
            pit_pkg::REQ_TICK: begin
                if (r_run) begin
                    if (r_presc_cnt >= r_prescale) begin
                        n_presc_cnt = '0;
                        step        = 1'b1;
                    end else begin
                        n_presc_cnt = CW'(r_presc_cnt + 1'b1);
                    end
                end
            end
            pit_pkg::REQ_START: begin
                n_presc_cnt = '0;
                n_count     = down ? r_reload : '0;
                load_cmp    = 1'b1;
                n_run       = 1'b1;
            end
            pit_pkg::REQ_STOP: begin
                n_run = 1'b0;
            end
            pit_pkg::REQ_WRITE: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (i_channel == pit_pkg::ChanW'(c)) begin
                        n_cmp_pending[c] = i_value;
                    end
                end
            end
            pit_pkg::REQ_CLEAR: begin
                n_wrap = 1'b0;
            end
            default: ;
        endcase

        if (step) begin
            if (down) begin
                if (r_count == '0) begin
                    n_count = r_reload;
                    wrapped = 1'b1;
                end else begin
                    n_count = CW'(r_count - 1'b1);
                end
            end else begin
                if (r_count >= r_reload) begin
                    n_count = '0;
                    wrapped = 1'b1;
                end else begin
                    n_count = CW'(r_count + 1'b1);
                end
            end
        end

        if (wrapped) begin
            n_wrap   = 1'b1;
            load_cmp = 1'b1;
            if (r_mode[pit_pkg::MODE_SINGLE]) begin
                n_run = 1'b0;
            end
        end

        // Pending compares are those before any write in this same item.
        if (load_cmp) begin
            n_cmp_active = r_cmp_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc_cnt <= '0;
            r_count     <= '0;
            r_run       <= 1'b0;
            r_wrap      <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cmp_active[c]  <= '0;
                r_cmp_pending[c] <= '0;
            end
        end else if (in_accept) begin
            r_presc_cnt   <= n_presc_cnt;
            r_count       <= n_count;
            r_run         <= n_run;
            r_wrap        <= n_wrap;
            r_cmp_active  <= n_cmp_active;
            r_cmp_pending <= n_cmp_pending;
        end
    end

    // PWM levels from the registered state.
    always_comb begin
        logic [2:0] bits;
        logic       act;
        pwm_levels = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            bits = r_setup[3*c +: 3];
            act  = down ? (r_count <= r_cmp_active[c]) : (r_count < r_cmp_active[c]);
            act  = act ^ bits[pit_pkg::CH_MODE2] ^ bits[pit_pkg::CH_ACT_LOW];
            pwm_levels[c] = bits[pit_pkg::CH_ENABLE] && act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_pwm_out           <= pwm_levels;
            o_count_value       <= r_count;
            o_update_flag       <= r_wrap;
            o_interrupt_request <= r_wrap && r_mode[pit_pkg::MODE_IRQ_EN];
            o_counting          <= r_run;
        end
    end

`ifndef SYNTHESIS
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && o_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    a_irq_implies_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_interrupt_request) |-> o_update_flag)
        else $error("interrupt request without update flag");

    a_stop_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req_type == pit_pkg::REQ_STOP) |=> !r_run)
        else $error("stop request left the counter running");

    a_start_sets_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req_type == pit_pkg::REQ_START) |=> (r_run && r_presc_cnt == '0))
        else $error("start request did not restart the counter");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the PWM interval timer: a directed table, then random phases checked by a predictor.
module tb_top;

    // Request codes the block must ignore.
    localparam logic [pit_pkg::ReqW-1:0] REQ_NONE_LO = 3'd5;
    localparam logic [pit_pkg::ReqW-1:0] REQ_NONE_HI = 3'd7;

    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 96;
    localparam int unsigned ROWS          = 32;

    typedef struct packed {
        logic [pit_pkg::MaxChannels-1:0] pwm;
        logic [pit_pkg::CountW-1:0]      count;
        logic                            flag;
        logic                            irq;
        logic                            run;
    } t_timer_readout;

    // A configuration row reuses the channel field as register index and value as data.
    typedef struct packed {
        logic                       is_cfg;
        logic [pit_pkg::ReqW-1:0]   req;
        logic [pit_pkg::ChanW-1:0]  ch;
        logic [pit_pkg::CountW-1:0] val;
        logic                       typed;
        t_timer_readout             want;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [ROWS] = '{
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b1, '0},
        '{1'b0, REQ_NONE_LO,          2'd3,                  16'hFFFF, 1'b1, '0},
        '{1'b0, REQ_NONE_HI,          2'd0,                  16'h0000, 1'b1, '0},
        '{1'b0, pit_pkg::REQ_STOP,    2'd0,                  16'h0000, 1'b1, '0},
        '{1'b0, pit_pkg::REQ_CLEAR,   2'd0,                  16'h0000, 1'b1, '0},
        '{1'b0, pit_pkg::REQ_WRITE,   2'd0,                  16'hFFFF, 1'b1, '0},
        '{1'b0, pit_pkg::REQ_WRITE,   2'd1,                  16'h0000, 1'b1, '0},
        '{1'b0, pit_pkg::REQ_WRITE,   2'd2,                  16'h0002, 1'b1, '0},
        '{1'b0, pit_pkg::REQ_WRITE,   2'd3,                  16'h0001, 1'b1, '0},
        '{1'b1, pit_pkg::REQ_TICK,    pit_pkg::CFG_RELOAD,   16'd2,    1'b0, '0},
        '{1'b1, pit_pkg::REQ_TICK,    pit_pkg::CFG_MODE,
            16'((1 << pit_pkg::MODE_SINGLE) | (1 << pit_pkg::MODE_IRQ_EN)), 1'b0, '0},
        // Channel 0 plain, 1 in mode two, 2 active low, 3 both.
        '{1'b1, pit_pkg::REQ_TICK,    pit_pkg::CFG_SETUP,    16'h0F59, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_START,   2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_CLEAR,   2'd0,                  16'h0000, 1'b0, '0},
        '{1'b1, pit_pkg::REQ_TICK,    pit_pkg::CFG_PRESCALE, 16'd1,    1'b0, '0},
        '{1'b1, pit_pkg::REQ_TICK,    pit_pkg::CFG_MODE,
            16'(1 << pit_pkg::MODE_DOWN), 1'b0, '0},
        '{1'b0, pit_pkg::REQ_START,   2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_WRITE,   2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b1, pit_pkg::REQ_TICK,    pit_pkg::CFG_PRESCALE, 16'hFFFF, 1'b0, '0},
        '{1'b1, pit_pkg::REQ_TICK,    pit_pkg::CFG_RELOAD,   16'd0,    1'b0, '0},
        '{1'b0, pit_pkg::REQ_TICK,    2'd0,                  16'h0000, 1'b0, '0},
        '{1'b0, pit_pkg::REQ_START,   2'd0,                  16'h0000, 1'b0, '0}
    };

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [pit_pkg::CfgIdxW-1:0]     i_cfg_index = '0;
    logic [pit_pkg::CfgDataW-1:0]    i_cfg_data  = '0;
    logic                            i_valid     = 1'b0;
    logic                            o_stall;
    logic [pit_pkg::ReqW-1:0]        i_req_type  = '0;
    logic [pit_pkg::ChanW-1:0]       i_channel   = '0;
    logic [pit_pkg::CountW-1:0]      i_value     = '0;
    logic                            o_valid;
    logic                            i_stall     = 1'b0;
    logic [pit_pkg::MaxChannels-1:0] o_pwm_out;
    logic [pit_pkg::CountW-1:0]      o_count_value;
    logic                            o_update_flag;
    logic                            o_interrupt_request;
    logic                            o_counting;

    // Predictor copy of the registers and the timer state.
    logic [pit_pkg::CountW-1:0]      cfg_prescale = '0;
    logic [pit_pkg::CountW-1:0]      cfg_reload   = pit_pkg::ReloadReset;
    logic [pit_pkg::ModeW-1:0]       cfg_mode     = '0;
    logic [pit_pkg::SetupW-1:0]      cfg_setup    = '0;
    logic [pit_pkg::CountW-1:0]      tick_div     = '0;
    logic [pit_pkg::CountW-1:0]      timer_count  = '0;
    logic                            timer_run    = 1'b0;
    logic                            timer_wrap   = 1'b0;
    logic [pit_pkg::CountW-1:0]      cmp_live [pit_pkg::MaxChannels] = '{default: '0};
    logic [pit_pkg::CountW-1:0]      cmp_next [pit_pkg::MaxChannels] = '{default: '0};

    t_timer_readout         timer_readouts_due [$];
    int unsigned            mismatches  = 0;
    int unsigned            cycle_count = 0;
    bit                     quiet_run   = 1'b0;

    pwm_interval_timer u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_req_type          (i_req_type),
        .i_channel           (i_channel),
        .i_value             (i_value),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_pwm_out           (o_pwm_out),
        .o_count_value       (o_count_value),
        .o_update_flag       (o_update_flag),
        .o_interrupt_request (o_interrupt_request),
        .o_counting          (o_counting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one item to the predicted timer and returns the outputs that follow it.
    function automatic t_timer_readout advance_timer(input logic [pit_pkg::ReqW-1:0] req,
                                                     input logic [pit_pkg::ChanW-1:0] ch,
                                                     input logic [pit_pkg::CountW-1:0] val);
        t_timer_readout r;
        logic           down;
        logic           wrapped;
        logic [2:0]     bits;
        logic           lvl;
        down    = cfg_mode[pit_pkg::MODE_DOWN];
        wrapped = 1'b0;
        case (req)
            pit_pkg::REQ_TICK: begin
                if (timer_run) begin
                    if (tick_div >= cfg_prescale) begin
                        tick_div = '0;
                        if (down) begin
                            if (timer_count == '0) begin
                                timer_count = cfg_reload;
                                wrapped = 1'b1;
                            end else begin
                                timer_count = timer_count - 1'b1;
                            end
                        end else if (timer_count >= cfg_reload) begin
                            timer_count = '0;
                            wrapped = 1'b1;
                        end else begin
                            timer_count = timer_count + 1'b1;
                        end
                        if (wrapped) begin
                            timer_wrap = 1'b1;
                            cmp_live = cmp_next;
                            if (cfg_mode[pit_pkg::MODE_SINGLE]) timer_run = 1'b0;
                        end
                    end else begin
                        tick_div = tick_div + 1'b1;
                    end
                end
            end
            pit_pkg::REQ_START: begin
                tick_div    = '0;
                timer_count = down ? cfg_reload : '0;
                cmp_live    = cmp_next;
                timer_run   = 1'b1;
            end
            pit_pkg::REQ_STOP: timer_run = 1'b0;
            pit_pkg::REQ_WRITE: begin
                if (ch < pit_pkg::NumChannelsDef) cmp_next[ch] = val;
            end
            pit_pkg::REQ_CLEAR: timer_wrap = 1'b0;
            default: ;
        endcase
        r.pwm = '0;
        for (int c = 0; c < pit_pkg::NumChannelsDef; c++) begin
            bits = cfg_setup[3*c +: 3];
            if (bits[pit_pkg::CH_ENABLE]) begin
                lvl = down ? (timer_count <= cmp_live[c]) : (timer_count < cmp_live[c]);
                r.pwm[c] = lvl ^ bits[pit_pkg::CH_MODE2] ^ bits[pit_pkg::CH_ACT_LOW];
            end
        end
        r.count = timer_count;
        r.flag  = timer_wrap;
        r.irq   = timer_wrap & cfg_mode[pit_pkg::MODE_IRQ_EN];
        r.run   = timer_run;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_item(input logic [pit_pkg::ReqW-1:0] req,
                             input logic [pit_pkg::ChanW-1:0] ch,
                             input logic [pit_pkg::CountW-1:0] val, input logic typed,
                             input t_timer_readout want);
        t_timer_readout predicted;
        if (!quiet_run && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_channel  <= ch;
        i_value    <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = advance_timer(req, ch, val);
        timer_readouts_due.push_back(typed ? want : predicted);
    endtask

    // Holds the sender back until every outstanding item has produced its result.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (timer_readouts_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pit_pkg::CfgIdxW-1:0] idx,
                             input logic [pit_pkg::CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pit_pkg::CFG_PRESCALE: cfg_prescale = data;
            pit_pkg::CFG_RELOAD:   cfg_reload   = data;
            pit_pkg::CFG_MODE:     cfg_mode     = data[pit_pkg::ModeW-1:0];
            pit_pkg::CFG_SETUP:    cfg_setup    = data[pit_pkg::SetupW-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Mostly ticks on a running timer, with restarts, stops, duty changes, flag clears and ignored codes mixed in.
    task automatic run_phase(input int unsigned n_items);
        int unsigned                counted;
        int unsigned                pick;
        logic [pit_pkg::ReqW-1:0]   req;
        logic [pit_pkg::CountW-1:0] val;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(99);
            val  = $urandom_range(1) ? 16'($urandom_range(26)) : 16'($urandom_range(65535));
            if (!timer_run && $urandom_range(3) == 0) req = pit_pkg::REQ_START;
            else if (pick < 70) req = pit_pkg::REQ_TICK;
            else if (pick < 80) req = pit_pkg::REQ_WRITE;
            else if (pick < 87) req = pit_pkg::REQ_CLEAR;
            else if (pick < 90) req = pit_pkg::REQ_START;
            else if (pick < 93) req = pit_pkg::REQ_STOP;
            else req = 3'($urandom_range(REQ_NONE_LO, REQ_NONE_HI));
            send_item(req, 2'($urandom_range(3)), val, 1'b0, '0);
            counted++;
            if ($urandom_range(199) == 0) wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !quiet_run && ($urandom_range(99) < 20);
        end
    end

    always @(posedge i_clk) begin
        t_timer_readout want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (timer_readouts_due.size() == 0) begin
                $display("%0t: result with no item outstanding, count %0h", $time,
                         o_count_value);
                mismatches++;
            end else begin
                want = timer_readouts_due.pop_front();
                check_field("pwm_out", 32'(want.pwm), 32'(o_pwm_out));
                check_field("count_value", 32'(want.count), 32'(o_count_value));
                check_field("update_flag", 32'(want.flag), 32'(o_update_flag));
                check_field("interrupt_request", 32'(want.irq), 32'(o_interrupt_request));
                check_field("counting", 32'(want.run), 32'(o_counting));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     timer_readouts_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [pit_pkg::CountW-1:0] prescale;
        logic [pit_pkg::CountW-1:0] reload;
        logic [pit_pkg::ModeW-1:0]  mode;
        logic [pit_pkg::SetupW-1:0] setup;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < ROWS; i++) begin
            if (DIRECTED_ROWS[i].is_cfg) begin
                wait_idle();
                write_reg(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].val);
            end else begin
                send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].val,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            end
        end

        // The timer keeps running across phases, so a new reload or prescale value can
        // find the counters already beyond it.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            quiet_run = (ph == 3);
            case ($urandom_range(7))
                0:       prescale = '1;
                1:       prescale = 16'($urandom_range(65535));
                default: prescale = 16'($urandom_range(2));
            endcase
            case ($urandom_range(7))
                0:       reload = '0;
                1:       reload = '1;
                2:       reload = 16'($urandom_range(65535));
                default: reload = 16'($urandom_range(1, 16));
            endcase
            mode  = (ph == 1) ? '1 : (ph == 2) ? '0 : 3'($urandom_range(7));
            setup = (ph == 1) ? '1 : (ph == 2) ? '0 : 12'($urandom_range(4095));
            write_reg(pit_pkg::CFG_PRESCALE, prescale);
            write_reg(pit_pkg::CFG_RELOAD, reload);
            write_reg(pit_pkg::CFG_MODE, 16'(mode));
            write_reg(pit_pkg::CFG_SETUP, 16'(setup));
            run_phase(PHASE_ITEMS);
        end
        quiet_run = 1'b0;

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
